// ===== hw/rtl/smoothed_rate_meter_macros.svh =====
// ---------------------------------------------------------------------------
// smoothed_rate_meter assertion macros
// Concurrent check wrappers; they expand to nothing in synthesis builds.
// ---------------------------------------------------------------------------
`ifndef SMOOTHED_RATE_METER_MACROS_SVH
`define SMOOTHED_RATE_METER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off while rst_n is low
`define SRM_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("smoothed_rate_meter: check failed");
// next-cycle implication
`define SRM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("smoothed_rate_meter: check failed");
`else
`define SRM_ASSERT_IMPL(lbl, ante, cons)
`define SRM_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== hw/rtl/srm_pkg.sv =====
// ---------------------------------------------------------------------------
// srm_pkg
// Widths, codes, types and helpers shared by the rate meter modules.
// ---------------------------------------------------------------------------
package srm_pkg;

  // fixed point and field widths
  localparam int FRAC_BITS = 8;
  localparam int RATE_W    = 30;
  localparam int MAXR_W    = 22;
  localparam int MS_W      = 16;
  localparam int FLOOR_W   = 10;
  localparam int TIME_W    = 32;
  localparam int EVT_W     = 64;
  localparam int OUTC_W    = 3;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = MAXR_W;

  // stream packing
  localparam int IN_ACTIVE_LSB = 0;
  localparam int IN_NOW_LSB    = IN_ACTIVE_LSB + 1;
  localparam int IN_EVT_LSB    = IN_NOW_LSB + TIME_W;
  localparam int IN_FIELDS_W   = IN_EVT_LSB + EVT_W;
  localparam int IN_DATA_W     = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W  = RATE_W + OUTC_W;
  localparam int OUT_DATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;

  // arithmetic widths
  localparam int PROD_W    = MAXR_W + MS_W;        // max_rate * elapsed
  localparam int INST_W    = MAXR_W + FRAC_BITS;   // window rate, bounded by max_rate
  localparam int MAC_A_W   = PROD_W;
  localparam int MAC_B_W   = MS_W;
  localparam int MAC_P_W   = MAC_A_W + MAC_B_W;
  localparam int DIV_N_W   = PROD_W + FRAC_BITS;
  localparam int DIV_D_W   = MS_W;
  localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

  localparam logic [RATE_W-1:0] RATE_MASK = {RATE_W{1'b1}};
  localparam logic [RATE_W-1:0] RATE_ONE  = RATE_W'(1) << FRAC_BITS;

  // constant factors: 0.92 = 23/25, 0.88/0.12 blend = (22*old + 3*new)/25
  localparam logic [MAC_B_W-1:0] K_DECAY_MUL = MAC_B_W'(23);
  localparam logic [MAC_B_W-1:0] K_OLD_MUL   = MAC_B_W'(22);
  localparam logic [MAC_B_W-1:0] K_NEW_MUL   = MAC_B_W'(3);
  localparam logic [MAC_B_W-1:0] K_MS_PER_S  = MAC_B_W'(1000);
  localparam logic [DIV_D_W-1:0] K_SMOOTH_DIV = DIV_D_W'(25);

  // register reset values
  localparam logic [MAXR_W-1:0]  RST_MAX_RATE  = MAXR_W'(2000000);
  localparam logic [MS_W-1:0]    RST_FIRST_WIN = MS_W'(500);
  localparam logic [MS_W-1:0]    RST_WIN       = MS_W'(1200);
  localparam logic [MS_W-1:0]    RST_STALE     = MS_W'(10000);
  localparam logic [FLOOR_W-1:0] RST_FLOOR     = FLOOR_W'(40);

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_MAX_RATE   = 3'd0,
    CFG_FIRST_WIN  = 3'd1,
    CFG_WIN        = 3'd2,
    CFG_STALE      = 3'd3,
    CFG_IDLE_FLOOR = 3'd4
  } cfg_idx_t;

  typedef enum logic [OUTC_W-1:0] {
    OUT_DECAY   = 3'd0,
    OUT_OPENED  = 3'd1,
    OUT_WAITING = 3'd2,
    OUT_STALE   = 3'd3,
    OUT_IMPLAUS = 3'd4,
    OUT_EMPTY   = 3'd5,
    OUT_UPDATED = 3'd6
  } outcome_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EVAL,
    S_CHK,
    S_LIM_MUL,
    S_DLT_MUL,
    S_INST_DIV,
    S_BL_NEW,
    S_BL_OLD,
    S_BL_DIV,
    S_DEC_MUL,
    S_DEC_DIV,
    S_FIN
  } state_t;

  typedef struct packed {
    logic               start;
    logic [MAC_A_W-1:0] a;
    logic [MAC_B_W-1:0] b;
    logic [MAC_P_W-1:0] c;
  } mac_req_t;

  typedef struct packed {
    logic               busy;
    logic [MAC_P_W-1:0] p;
  } mac_rsp_t;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] num;
    logic [DIV_D_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic [DIV_N_W-1:0] quo;
  } div_rsp_t;

  // clamp limit: max_rate in q format, never above the rate field
  function automatic logic [RATE_W-1:0] rate_cap(input logic [MAXR_W-1:0] max_hs);
    logic [DIV_N_W-1:0] cap;
    cap = DIV_N_W'(max_hs) << FRAC_BITS;
    if (cap > DIV_N_W'(RATE_MASK)) rate_cap = RATE_MASK;
    else rate_cap = cap[RATE_W-1:0];
  endfunction

  function automatic logic [RATE_W-1:0] sat_rate(input logic [DIV_N_W-1:0] v,
                                                 input logic [RATE_W-1:0]  cap);
    if (v > DIV_N_W'(cap)) sat_rate = cap;
    else sat_rate = v[RATE_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/srm_smac.sv =====
// ---------------------------------------------------------------------------
// srm_smac
// Bit-serial multiply-accumulate: p = c + a*b, one multiplier bit a cycle.
// ---------------------------------------------------------------------------
module srm_smac import srm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  mac_req_t req,
  output mac_rsp_t rsp
);

  logic [MAC_P_W-1:0] a_r, a_nxt;
  logic [MAC_P_W-1:0] acc_r, acc_nxt;
  logic [MAC_B_W-1:0] b_r, b_nxt;

  // stops as soon as no multiplier bits remain
  always_comb begin
    a_nxt   = a_r;
    b_nxt   = b_r;
    acc_nxt = acc_r;
    if (req.start) begin
      a_nxt   = MAC_P_W'(req.a);
      b_nxt   = req.b;
      acc_nxt = req.c;
    end else if (b_r != '0) begin
      if (b_r[0]) acc_nxt = acc_r + a_r;
      a_nxt = a_r << 1;
      b_nxt = b_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_r <= '0;
    end else begin
      b_r <= b_nxt;
    end
    a_r   <= a_nxt;
    acc_r <= acc_nxt;
  end

  assign rsp.busy = (b_r != '0);
  assign rsp.p    = acc_r;

endmodule

// ===== hw/rtl/srm_sdiv.sv =====
// ---------------------------------------------------------------------------
// srm_sdiv
// Restoring divider, one quotient bit a cycle.
// ---------------------------------------------------------------------------
module srm_sdiv import srm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIV_N_W-1:0]   q_r, q_nxt;
  logic [DIV_D_W-1:0]   rem_r, rem_nxt;
  logic [DIV_D_W-1:0]   den_r, den_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_D_W:0]     trial;

  // dividend shifts out of q_r from the top, quotient bits shift in below
  always_comb begin
    q_nxt   = q_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    cnt_nxt = cnt_r;
    trial   = {rem_r, q_r[DIV_N_W-1]} - {1'b0, den_r};
    if (req.start) begin
      q_nxt   = req.num;
      rem_nxt = '0;
      den_nxt = req.den;
      cnt_nxt = DIV_CNT_W'(DIV_N_W);
    end else if (cnt_r != '0) begin
      if (trial[DIV_D_W]) rem_nxt = {rem_r[DIV_D_W-2:0], q_r[DIV_N_W-1]};
      else rem_nxt = trial[DIV_D_W-1:0];
      q_nxt   = {q_r[DIV_N_W-2:0], ~trial[DIV_D_W]};
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign rsp.busy = (cnt_r != '0);
  assign rsp.quo  = q_r;

endmodule

// ===== hw/rtl/smoothed_rate_meter.sv =====
// ---------------------------------------------------------------------------
// smoothed_rate_meter
// Sequence: rebase, open and zero-rate decay ticks go from accept to the
//   registered word directly; wait and stale ticks add a check state; a decay
//   runs one MAC and one divide; empty and implausible ticks may use the serial
//   MAC; an update uses the MAC and one or two divides on the shared serial
//   divider. One word in flight; the next is accepted in the cycle after the previous result is registered.
// Reset: synchronous, active low; rate, window and handshake state cleared,
//   configuration back to its defaults.
// ---------------------------------------------------------------------------
`include "smoothed_rate_meter_macros.svh"

module smoothed_rate_meter import srm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [0] active, [32:1] now_ms, [96:33] event_count
  input  logic                  in_tuser,   // [0] op
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [29:0] rate_q8, [32:30] outcome
  // configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // -------------------------------------------------------------------------
  // declarations
  // -------------------------------------------------------------------------
  state_t st_r, st_nxt;

  // latched input word
  logic              op_r;
  logic              active_r;
  logic [TIME_W-1:0] now_r;
  logic [EVT_W-1:0]  evt_r;

  // per-word working registers
  logic [TIME_W-1:0] elapsed_r, elapsed_nxt;
  logic [EVT_W-1:0]  delta_r, delta_nxt;
  logic [PROD_W-1:0] lim_r, lim_nxt;
  logic [RATE_W-1:0] res_rate_r, res_rate_nxt;
  outcome_t          res_outc_r, res_outc_nxt;

  // meter state
  logic [RATE_W-1:0] rate_r;
  logic [TIME_W-1:0] win_start_r;
  logic [EVT_W-1:0]  base_r;
  logic              win_open_r;

  // configuration
  logic [MAXR_W-1:0]  max_rate_r;
  logic [MS_W-1:0]    first_win_r;
  logic [MS_W-1:0]    win_r;
  logic [MS_W-1:0]    stale_r;
  logic [FLOOR_W-1:0] floor_r;

  // output register
  logic              out_tvalid_r;
  logic [RATE_W-1:0] out_rate_r;
  outcome_t          out_outc_r;

  // serial units
  mac_req_t mac_req;
  mac_rsp_t mac_rsp;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic               accept;
  logic               commit;
  logic               mac_done;
  logic               div_done;
  logic               rate_le_one;
  logic               dec_go;
  logic [MS_W-1:0]    need_ms;
  logic               chk_wait;
  logic               chk_stale;
  logic               chk_far;
  logic               dlt_impl;
  logic               dlt_empty;
  logic [RATE_W-1:0]  cap;
  logic [DIV_N_W-1:0] floor_q;

  // -------------------------------------------------------------------------
  // arithmetic units: one MAC and one divider, used one at a time
  // -------------------------------------------------------------------------
  srm_smac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mac_req),
    .rsp   (mac_rsp)
  );

  srm_sdiv u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // -------------------------------------------------------------------------
  // decision terms
  // -------------------------------------------------------------------------
  assign accept   = in_tvalid && in_tready;
  assign mac_done = !mac_rsp.busy;
  assign div_done = !div_rsp.busy;

  // the short first window applies while no real rate exists yet
  assign rate_le_one = (rate_r <= RATE_ONE);
  assign need_ms     = rate_le_one ? first_win_r : win_r;
  assign dec_go      = !active_r && (rate_r != '0);

  assign chk_wait  = elapsed_r < TIME_W'(need_ms);
  assign chk_stale = elapsed_r > TIME_W'(stale_r);
  // a delta this large beats any max_rate*elapsed; also catches a counter
  // that went backwards
  assign chk_far   = (delta_r[EVT_W-1:PROD_W] != '0);

  // plausibility without a divide: delta*1000 > max_rate*elapsed
  assign dlt_impl  = mac_rsp.p > MAC_P_W'(lim_r);
  assign dlt_empty = (delta_r == '0);

  assign cap     = rate_cap(max_rate_r);
  assign floor_q = DIV_N_W'(floor_r) << FRAC_BITS;

  // -------------------------------------------------------------------------
  // sequencer: next state
  // -------------------------------------------------------------------------
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: begin
        if (accept) st_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (op_r) st_nxt = S_FIN;
        else if (!active_r) st_nxt = dec_go ? S_DEC_MUL : S_FIN;
        else if (!win_open_r) st_nxt = S_FIN;
        else st_nxt = S_CHK;
      end
      S_CHK: begin
        if (chk_wait || chk_stale || chk_far) st_nxt = S_FIN;
        else st_nxt = S_LIM_MUL;
      end
      S_LIM_MUL: begin
        if (mac_done) st_nxt = S_DLT_MUL;
      end
      S_DLT_MUL: begin
        if (mac_done) st_nxt = (dlt_impl || dlt_empty) ? S_FIN : S_INST_DIV;
      end
      S_INST_DIV: begin
        if (div_done) st_nxt = rate_le_one ? S_FIN : S_BL_NEW;
      end
      S_BL_NEW: begin
        if (mac_done) st_nxt = S_BL_OLD;
      end
      S_BL_OLD: begin
        if (mac_done) st_nxt = S_BL_DIV;
      end
      S_BL_DIV: begin
        if (div_done) st_nxt = S_FIN;
      end
      S_DEC_MUL: begin
        if (mac_done) st_nxt = S_DEC_DIV;
      end
      S_DEC_DIV: begin
        if (div_done) st_nxt = S_FIN;
      end
      S_FIN: begin
        if (commit) st_nxt = S_IDLE;
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  // -------------------------------------------------------------------------
  // sequencer: outputs (handshake, commit, unit launches)
  // -------------------------------------------------------------------------
  always_comb begin
    in_tready = (st_r == S_IDLE);
    // the result goes out once the output register is free or draining
    commit    = (st_r == S_FIN) && (!out_tvalid_r || out_tready);
    mac_req   = '0;
    div_req   = '0;
    case (st_r)
      S_EVAL: begin
        // decay: rate*23, then /25
        if (!op_r && dec_go) begin
          mac_req.start = 1'b1;
          mac_req.a     = MAC_A_W'(rate_r);
          mac_req.b     = K_DECAY_MUL;
        end
      end
      S_CHK: begin
        // elapsed is within stale_ms here, so it fits the short operand
        if (!(chk_wait || chk_stale || chk_far)) begin
          mac_req.start = 1'b1;
          mac_req.a     = MAC_A_W'(max_rate_r);
          mac_req.b     = elapsed_r[MS_W-1:0];
        end
      end
      S_LIM_MUL: begin
        if (mac_done) begin
          mac_req.start = 1'b1;
          mac_req.a     = delta_r[PROD_W-1:0];
          mac_req.b     = K_MS_PER_S;
        end
      end
      S_DLT_MUL: begin
        // plausible, so delta*1000 fits PROD_W and elapsed is nonzero
        if (mac_done && !(dlt_impl || dlt_empty)) begin
          div_req.start = 1'b1;
          div_req.num   = {mac_rsp.p[PROD_W-1:0], {FRAC_BITS{1'b0}}};
          div_req.den   = elapsed_r[MS_W-1:0];
        end
      end
      S_INST_DIV: begin
        if (div_done && !rate_le_one) begin
          mac_req.start = 1'b1;
          mac_req.a     = MAC_A_W'(div_rsp.quo[INST_W-1:0]);
          mac_req.b     = K_NEW_MUL;
        end
      end
      S_BL_NEW: begin
        // accumulate 22*old on top of 3*new
        if (mac_done) begin
          mac_req.start = 1'b1;
          mac_req.a     = MAC_A_W'(rate_r);
          mac_req.b     = K_OLD_MUL;
          mac_req.c     = mac_rsp.p;
        end
      end
      S_BL_OLD: begin
        if (mac_done) begin
          div_req.start = 1'b1;
          div_req.num   = mac_rsp.p[DIV_N_W-1:0];
          div_req.den   = K_SMOOTH_DIV;
        end
      end
      S_DEC_MUL: begin
        if (mac_done) begin
          div_req.start = 1'b1;
          div_req.num   = mac_rsp.p[DIV_N_W-1:0];
          div_req.den   = K_SMOOTH_DIV;
        end
      end
      default: begin
      end
    endcase
  end

  // -------------------------------------------------------------------------
  // working registers
  // -------------------------------------------------------------------------
  always_comb begin
    elapsed_nxt  = elapsed_r;
    delta_nxt    = delta_r;
    lim_nxt      = lim_r;
    res_rate_nxt = res_rate_r;
    res_outc_nxt = res_outc_r;
    case (st_r)
      S_EVAL: begin
        // both differences wrap, as the time and count inputs do
        elapsed_nxt  = now_r - win_start_r;
        delta_nxt    = evt_r - base_r;
        res_rate_nxt = rate_r;
        if (op_r || (active_r && !win_open_r)) res_outc_nxt = OUT_OPENED;
        else if (!active_r) res_outc_nxt = OUT_DECAY;
      end
      S_CHK: begin
        if (chk_wait) res_outc_nxt = OUT_WAITING;
        else if (chk_stale) res_outc_nxt = OUT_STALE;
        else if (chk_far) res_outc_nxt = OUT_IMPLAUS;
      end
      S_LIM_MUL: begin
        if (mac_done) lim_nxt = mac_rsp.p[PROD_W-1:0];
      end
      S_DLT_MUL: begin
        if (mac_done) begin
          if (dlt_impl) res_outc_nxt = OUT_IMPLAUS;
          else if (dlt_empty) res_outc_nxt = OUT_EMPTY;
        end
      end
      S_INST_DIV: begin
        // first real sample loads the window rate directly
        if (div_done) begin
          res_outc_nxt = OUT_UPDATED;
          if (rate_le_one) res_rate_nxt = sat_rate(div_rsp.quo, cap);
        end
      end
      S_BL_DIV: begin
        if (div_done) res_rate_nxt = sat_rate(div_rsp.quo, cap);
      end
      S_DEC_DIV: begin
        if (div_done) begin
          if (div_rsp.quo < floor_q) res_rate_nxt = '0;
          else res_rate_nxt = div_rsp.quo[RATE_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    if (accept) begin
      op_r     <= in_tuser;
      active_r <= in_tdata[IN_ACTIVE_LSB];
      now_r    <= in_tdata[IN_NOW_LSB +: TIME_W];
      evt_r    <= in_tdata[IN_EVT_LSB +: EVT_W];
    end
    elapsed_r  <= elapsed_nxt;
    delta_r    <= delta_nxt;
    lim_r      <= lim_nxt;
    res_rate_r <= res_rate_nxt;
    res_outc_r <= res_outc_nxt;
  end

  // -------------------------------------------------------------------------
  // meter state: updated only when the word is handed to the output
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r      <= '0;
      win_start_r <= '0;
      base_r      <= '0;
      win_open_r  <= 1'b0;
    end else if (commit) begin
      rate_r <= res_rate_r;
      case (res_outc_r)
        OUT_OPENED: begin
          win_start_r <= now_r;
          base_r      <= evt_r;
          win_open_r  <= 1'b1;
        end
        OUT_STALE, OUT_IMPLAUS, OUT_UPDATED: begin
          win_start_r <= now_r;
          base_r      <= evt_r;
        end
        OUT_EMPTY: begin
          // empty window: restart the time, keep the baseline
          win_start_r <= now_r;
        end
        default: begin
        end
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // configuration registers; indexes past the list are ignored
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_rate_r  <= RST_MAX_RATE;
      first_win_r <= RST_FIRST_WIN;
      win_r       <= RST_WIN;
      stale_r     <= RST_STALE;
      floor_r     <= RST_FLOOR;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_MAX_RATE:   max_rate_r  <= cfg_wdata[MAXR_W-1:0];
        CFG_FIRST_WIN:  first_win_r <= cfg_wdata[MS_W-1:0];
        CFG_WIN:        win_r       <= cfg_wdata[MS_W-1:0];
        CFG_STALE:      stale_r     <= cfg_wdata[MS_W-1:0];
        CFG_IDLE_FLOOR: floor_r     <= cfg_wdata[FLOOR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // output register: holds one finished word while the next is taken in
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (commit) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
    if (commit) begin
      out_rate_r <= res_rate_r;
      out_outc_r <= res_outc_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_DATA_W'({out_outc_r, out_rate_r});

  // -------------------------------------------------------------------------
  // checks
  // -------------------------------------------------------------------------
  `SRM_ASSERT_IMPL(a_units_exclusive, 1'b1, !(mac_rsp.busy && div_rsp.busy))
  `SRM_ASSERT_NEXT(a_rate_held, !commit, $stable(rate_r))
  `SRM_ASSERT_IMPL(a_word_from_commit, $rose(out_tvalid_r), $past(commit))
  `SRM_ASSERT_NEXT(a_update_capped, commit && (res_outc_r == OUT_UPDATED), rate_r <= cap)

endmodule
